// ===== rtl/pud_pkg.sv =====
// Shared types and constants for the percent-escape / UTF-8 decoder.
package pud_pkg;

    localparam int BYTE_W    = 8;
    localparam int CP_W      = 21;
    localparam int MAX_RES   = 4;
    localparam int RES_CNT_W = 3;
    localparam int HELD_N    = 3;

    localparam logic [BYTE_W-1:0] PCT_CHAR = 8'h25;
    localparam logic [CP_W-1:0]   CP_MAX   = 21'h10FFFF;

    typedef enum logic [4:0] {
        KIND_NONE = 5'b00001,
        KIND_PCT  = 5'b00010,
        KIND_U2   = 5'b00100,
        KIND_U3   = 5'b01000,
        KIND_U4   = 5'b10000
    } pud_kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              in_last;
    } pud_in_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            bad_escape;
        logic            out_last;
    } pud_out_t;

    typedef struct packed {
        logic [RES_CNT_W-1:0]       count;
        pud_out_t [MAX_RES-1:0]     slot;
    } pud_batch_t;

endpackage

// ===== rtl/percent_utf8_decoder.sv =====
// Top level: percent-escape and UTF-8 decoder, one token byte per beat.
// Path: an accepted byte is registered in the input stage, decoded when the result buffer
//   is free, and its results are registered there before they appear on m_ (none if held).
// Throughput: one byte per cycle while each byte yields at most one result and m_ready is
//   high; a byte yielding more than one result (up to four) holds the result buffer until all are taken.
// Reset (aresetn, synchronous, low): clears valids, pending sequence and drop mode.
module percent_utf8_decoder
    import pud_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  pud_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output pud_out_t m_data
);

    logic       item_valid;
    pud_in_t    item;
    logic       free;
    logic       load;
    pud_batch_t batch;

    assign load = item_valid && free;

    pud_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .load       (load),
        .item_valid (item_valid),
        .item       (item)
    );

    pud_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (item),
        .load    (load),
        .batch   (batch)
    );

    pud_out_buf u_out_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .batch   (batch),
        .free    (free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== rtl/pud_in_stage.sv =====
// Input register that holds one byte beat until the decoder consumes it.
module pud_in_stage
    import pud_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  pud_in_t s_data,
    input  logic    load,
    output logic    item_valid,
    output pud_in_t item
);

    logic    valid_reg, valid_next;
    pud_in_t item_reg;

    assign s_ready    = !valid_reg || load;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (load) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

endmodule

// ===== rtl/pud_decode.sv =====
// Decoder state and the per-byte logic that builds one result batch.
module pud_decode
    import pud_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  pud_in_t    item,
    input  logic       load,
    output pud_batch_t batch
);

    logic [BYTE_W-1:0] held_reg  [HELD_N];
    logic [BYTE_W-1:0] held_next [HELD_N];
    logic [1:0]        count_reg, count_next;
    pud_kind_t         kind_reg, kind_next;
    logic              discard_reg, discard_next;

    logic [BYTE_W-1:0] b;
    logic              last;
    logic              pre_flush;
    logic              tail_valid;
    logic [CP_W-1:0]   tail_cp;
    logic              tail_bad;
    logic [1:0]        pre_n;
    logic [RES_CNT_W-1:0] res_n;
    pud_kind_t         fresh_kind;
    logic [7:0]        esc_val;
    logic [CP_W-1:0]   utf_cp;
    logic [CP_W-1:0]   lit_cp;
    logic              fin;

    function automatic logic is_hex(input logic [BYTE_W-1:0] x);
        return (x >= 8'h30 && x <= 8'h39) || (x >= 8'h61 && x <= 8'h66) ||
               (x >= 8'h41 && x <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [BYTE_W-1:0] x);
        logic [3:0] v;
        v = 4'd0;
        if (x >= 8'h30 && x <= 8'h39) begin
            v = x[3:0];
        end else if (is_hex(x)) begin
            v = x[3:0] + 4'd9;
        end
        return v;
    endfunction

    function automatic logic [2:0] kind_len(input pud_kind_t k);
        logic [2:0] len;
        unique case (k)
            KIND_U2: len = 3'd2;
            KIND_U3: len = 3'd3;
            KIND_U4: len = 3'd4;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    assign b      = item.in_byte;
    assign last   = item.in_last;
    assign lit_cp = {{(CP_W-BYTE_W){1'b0}}, b};

    always_comb begin
        priority if (b == PCT_CHAR) begin
            fresh_kind = KIND_PCT;
        end else if (b[7:5] == 3'b110) begin
            fresh_kind = KIND_U2;
        end else if (b[7:4] == 4'b1110) begin
            fresh_kind = KIND_U3;
        end else if (b[7:3] == 5'b11110) begin
            fresh_kind = KIND_U4;
        end else begin
            fresh_kind = KIND_NONE;
        end
    end

    assign esc_val = {hex_val(held_reg[1]), hex_val(b)};

    always_comb begin
        unique case (kind_reg)
            KIND_U2: utf_cp = {10'd0, held_reg[0][4:0], b[5:0]};
            KIND_U3: utf_cp = {5'd0, held_reg[0][3:0], held_reg[1][5:0], b[5:0]};
            default: utf_cp = {held_reg[0][2:0], held_reg[1][5:0], held_reg[2][5:0],
                               b[5:0]};
        endcase
    end

    always_comb begin
        held_next    = held_reg;
        count_next   = count_reg;
        kind_next    = kind_reg;
        discard_next = discard_reg;
        pre_flush    = 1'b0;
        tail_valid   = 1'b0;
        tail_cp      = lit_cp;
        tail_bad     = 1'b0;
        fin          = 1'b0;

        if (discard_reg) begin
            discard_next = !last;
        end else begin
            unique case (kind_reg)
                KIND_PCT: begin
                    if (is_hex(b) && count_reg < 2'd2) begin
                        // first digit: hold, or flush '%' and digit at token end
                        if (last) begin
                            pre_flush = 1'b1;
                            tail_valid = 1'b1;
                            fin = 1'b1;
                        end else begin
                            held_next[1] = b;
                            count_next = 2'd2;
                        end
                    end else if (is_hex(b)) begin
                        fin = 1'b1;
                        tail_valid = 1'b1;
                        if (esc_val[7]) begin
                            tail_bad = 1'b1;
                            tail_cp = '0;
                            discard_next = !last;
                        end else begin
                            tail_cp = {{(CP_W-8){1'b0}}, esc_val};
                        end
                    end else begin
                        pre_flush = 1'b1;
                        if (fresh_kind != KIND_NONE && !last) begin
                            held_next[0] = b;
                            count_next = 2'd1;
                            kind_next = fresh_kind;
                        end else begin
                            tail_valid = 1'b1;
                            fin = 1'b1;
                        end
                    end
                end
                KIND_U2, KIND_U3, KIND_U4: begin
                    if (b[7:6] == 2'b10 && ({1'b0, count_reg} + 3'd1) < kind_len(kind_reg)) begin
                        if (last) begin
                            pre_flush = 1'b1;
                            tail_valid = 1'b1;
                            fin = 1'b1;
                        end else begin
                            held_next[count_reg] = b;
                            count_next = count_reg + 2'd1;
                        end
                    end else if (b[7:6] == 2'b10) begin
                        fin = 1'b1;
                        tail_valid = 1'b1;
                        // out of range: flush the held bytes and this byte as Latin-1
                        if (utf_cp > CP_MAX) begin
                            pre_flush = 1'b1;
                        end else begin
                            tail_cp = utf_cp;
                        end
                    end else begin
                        pre_flush = 1'b1;
                        if (fresh_kind != KIND_NONE && !last) begin
                            held_next[0] = b;
                            count_next = 2'd1;
                            kind_next = fresh_kind;
                        end else begin
                            tail_valid = 1'b1;
                            fin = 1'b1;
                        end
                    end
                end
                default: begin
                    if (fresh_kind != KIND_NONE && !last) begin
                        held_next[0] = b;
                        count_next = 2'd1;
                        kind_next = fresh_kind;
                    end else begin
                        tail_valid = 1'b1;
                        fin = 1'b1;
                    end
                end
            endcase
            if (fin) begin
                count_next = 2'd0;
                kind_next = KIND_NONE;
            end
        end
    end

    assign pre_n = pre_flush ? count_reg : 2'd0;
    assign res_n = {1'b0, pre_n} + {2'b0, tail_valid};

    always_comb begin
        batch.count = res_n;
        batch.slot[0].code_point = (pre_n > 2'd0) ? {13'd0, held_reg[0]} : tail_cp;
        batch.slot[1].code_point = (pre_n > 2'd1) ? {13'd0, held_reg[1]} : tail_cp;
        batch.slot[2].code_point = (pre_n > 2'd2) ? {13'd0, held_reg[2]} : tail_cp;
        batch.slot[3].code_point = tail_cp;
        for (int k = 0; k < MAX_RES; k++) begin
            batch.slot[k].bad_escape = tail_bad && (res_n == RES_CNT_W'(k + 1));
            batch.slot[k].out_last   = (last || tail_bad) && (res_n == RES_CNT_W'(k + 1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= 2'd0;
            kind_reg    <= KIND_NONE;
            discard_reg <= 1'b0;
        end else if (load) begin
            count_reg   <= count_next;
            kind_reg    <= kind_next;
            discard_reg <= discard_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            held_reg <= held_next;
        end
    end

    a_discard_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        discard_reg |-> (kind_reg == KIND_NONE && count_reg == 2'd0))
        else $error("pending sequence while dropping a token");

    a_none_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (kind_reg == KIND_NONE) |-> (count_reg == 2'd0))
        else $error("held bytes with nothing pending");

    a_pct_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (kind_reg == KIND_PCT) |-> (count_reg == 2'd1 || count_reg == 2'd2))
        else $error("escape pending with bad held count");

endmodule

// ===== rtl/pud_out_buf.sv =====
// Result buffer that holds one batch and drains it one beat per cycle while m_ready is high.
module pud_out_buf
    import pud_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  pud_batch_t batch,
    output logic       free,
    output logic       m_valid,
    input  logic       m_ready,
    output pud_out_t   m_data
);

    pud_out_t [MAX_RES-1:0] slot_reg;
    logic [RES_CNT_W-1:0]   rem_reg, rem_next;
    logic [1:0]             idx_reg, idx_next;

    assign m_valid = (rem_reg != '0);
    assign m_data  = slot_reg[idx_reg];
    assign free    = (rem_reg == '0) || (rem_reg == RES_CNT_W'(1) && m_ready);

    always_comb begin
        rem_next = rem_reg;
        idx_next = idx_reg;
        if (load) begin
            rem_next = batch.count;
            idx_next = 2'd0;
        end else if (m_valid && m_ready) begin
            rem_next = rem_reg - RES_CNT_W'(1);
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
            idx_reg <= 2'd0;
        end else begin
            rem_reg <= rem_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            slot_reg <= batch.slot;
        end
    end

    a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, idx_reg} + rem_reg) <= RES_CNT_W'(MAX_RES))
        else $error("read index runs past the batch");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (rem_reg == '0 || (rem_reg == RES_CNT_W'(1) && m_ready)))
        else $error("batch loaded over undelivered results");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && batch.count != '0) |=> (m_valid && idx_reg == 2'd0))
        else $error("loaded batch not presented");

endmodule

// ===== dv/tb_percent_utf8_decoder.sv =====
// Testbench for percent_utf8_decoder: directed and random tokens against a byte-level predictor.
`timescale 1ns / 1ps

module tb_percent_utf8_decoder
    import pud_pkg::*;
();

    localparam int MAX_CYCLES = 200000;
    localparam int TAIL_CYCLES = 16;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    pud_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    pud_out_t m_data;

    // predictor state
    logic [7:0] held [0:2];
    int         held_n = 0;
    pud_kind_t  pend = KIND_NONE;
    logic       dropping = 1'b0;
    int         step_n;

    pud_out_t   expected_chars[$];
    pud_out_t   want;
    logic [7:0] tok_bytes[$];

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int live_bytes = 0;
    int mismatches = 0;
    int cycle_cnt = 0;

    percent_utf8_decoder DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic is_hex_digit(input logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] b);
        logic [7:0] v;
        if (b >= "0" && b <= "9")
            v = b - "0";
        else
            v = (b & 8'h0F) + 8'd9;
        return v[3:0];
    endfunction

    function automatic void emit_char(input logic [20:0] cp, input logic bad, input logic lst);
        pud_out_t r;
        r.code_point = cp;
        r.bad_escape = bad;
        r.out_last   = lst;
        expected_chars.push_back(r);
        step_n++;
    endfunction

    function automatic void flush_held();
        for (int i = 0; i < held_n; i++)
            emit_char({13'd0, held[i]}, 1'b0, 1'b0);
        held_n = 0;
        pend = KIND_NONE;
    endfunction

    function automatic void start_byte(input logic [7:0] b);
        if (b == PCT_CHAR)
            pend = KIND_PCT;
        else if (b[7:5] == 3'b110)
            pend = KIND_U2;
        else if (b[7:4] == 4'b1110)
            pend = KIND_U3;
        else if (b[7:3] == 5'b11110)
            pend = KIND_U4;
        else begin
            emit_char({13'd0, b}, 1'b0, 1'b0);
            return;
        end
        held[0] = b;
        held_n = 1;
    endfunction

    function automatic void decode_byte(input pud_in_t it);
        logic [7:0]  b;
        logic        lst;
        logic [7:0]  v;
        logic [20:0] cp;
        int          seq_len;
        pud_out_t    r;
        b = it.in_byte;
        lst = it.in_last;
        step_n = 0;
        if (dropping) begin
            if (lst)
                dropping = 1'b0;
            return;
        end
        case (pend)
            KIND_PCT: begin
                if (is_hex_digit(b)) begin
                    if (held_n < 2) begin
                        held[held_n] = b;
                        held_n++;
                    end else begin
                        v = {hex_nibble(held[1]), hex_nibble(b)};
                        held_n = 0;
                        pend = KIND_NONE;
                        // escape to a high byte: one error result, drop the rest of the token
                        if (v[7]) begin
                            emit_char('0, 1'b1, 1'b1);
                            dropping = !lst;
                            return;
                        end
                        emit_char({13'd0, v}, 1'b0, 1'b0);
                    end
                end else begin
                    flush_held();
                    start_byte(b);
                end
            end
            KIND_U2, KIND_U3, KIND_U4: begin
                seq_len = (pend == KIND_U2) ? 2 : (pend == KIND_U3) ? 3 : 4;
                if (b[7:6] == 2'b10) begin
                    if (held_n + 1 < seq_len) begin
                        held[held_n] = b;
                        held_n++;
                    end else begin
                        if (pend == KIND_U2)
                            cp = {10'd0, held[0][4:0], b[5:0]};
                        else if (pend == KIND_U3)
                            cp = {5'd0, held[0][3:0], held[1][5:0], b[5:0]};
                        else
                            cp = {held[0][2:0], held[1][5:0], held[2][5:0], b[5:0]};
                        if (cp > CP_MAX) begin
                            flush_held();
                            emit_char({13'd0, b}, 1'b0, 1'b0);
                        end else begin
                            held_n = 0;
                            pend = KIND_NONE;
                            emit_char(cp, 1'b0, 1'b0);
                        end
                    end
                end else begin
                    flush_held();
                    start_byte(b);
                end
            end
            default: begin
                held_n = 0;
                pend = KIND_NONE;
                start_byte(b);
            end
        endcase
        if (lst) begin
            flush_held();
            if (step_n > 0) begin
                r = expected_chars.pop_back();
                r.out_last = 1'b1;
                expected_chars.push_back(r);
            end
        end
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected beat cp=%h bad=%b last=%b",
                                          m_data.code_point, m_data.bad_escape, m_data.out_last));
            end else begin
                want = expected_chars.pop_front();
                if (m_data.code_point !== want.code_point)
                    report_mismatch($sformatf("code_point got %h want %h",
                                              m_data.code_point, want.code_point));
                if (m_data.bad_escape !== want.bad_escape)
                    report_mismatch($sformatf("bad_escape got %b want %b",
                                              m_data.bad_escape, want.bad_escape));
                if (m_data.out_last !== want.out_last)
                    report_mismatch($sformatf("out_last got %b want %b cp=%h",
                                              m_data.out_last, want.out_last, want.code_point));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt == MAX_CYCLES) begin
            $display("percent_utf8_decoder verification failed");
            $finish;
        end
    end

    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= sink_stall_pct);

    // ---------------------------------------------------------------- stimulus

    // entered and left just after a falling edge; valid stays high between beats unless an idle gap is drawn
    task automatic send_byte(input logic [7:0] b, input logic lst);
        pud_in_t it;
        it.in_byte = b;
        it.in_last = lst;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (!dropping)
            live_bytes++;
        decode_byte(it);
        @(negedge aclk);
    endtask

    task automatic send_token(input logic end_tok);
        for (int i = 0; i < tok_bytes.size(); i++)
            send_byte(tok_bytes[i], end_tok && (i == tok_bytes.size() - 1));
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 10)
            return "0" + n;
        return ($urandom_range(1) ? "A" : "a") + 8'(n) - 8'd10;
    endfunction

    task automatic build_token();
        int         pieces;
        int         len;
        logic [7:0] b;
        logic [3:0] hi;
        tok_bytes.delete();
        pieces = $urandom_range(1, 5);
        repeat (pieces) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    b = 8'($urandom_range(0, 127));
                    tok_bytes.push_back(b);
                end
                2, 3: begin
                    // low half gives a character, high half the error
                    hi = 4'($urandom);
                    tok_bytes.push_back(PCT_CHAR);
                    tok_bytes.push_back(hex_char(hi));
                    tok_bytes.push_back(hex_char(4'($urandom)));
                end
                4: begin
                    tok_bytes.push_back(PCT_CHAR);
                    if ($urandom_range(1))
                        tok_bytes.push_back(hex_char(4'($urandom)));
                    b = 8'($urandom);
                    if (is_hex_digit(b))
                        b = "G";
                    if ($urandom_range(2) != 0)
                        tok_bytes.push_back(b);
                end
                5, 6, 7: begin
                    len = $urandom_range(2, 4);
                    b = 8'($urandom);
                    if (len == 2)
                        tok_bytes.push_back({3'b110, b[4:0]});
                    else if (len == 3)
                        tok_bytes.push_back({4'b1110, b[3:0]});
                    else
                        tok_bytes.push_back({5'b11110, b[2:0]});
                    repeat (len - 1) begin
                        b = 8'($urandom);
                        tok_bytes.push_back({2'b10, b[5:0]});
                    end
                end
                8: begin
                    // truncated sequence: lead plus too few continuations
                    len = $urandom_range(2, 4);
                    b = 8'($urandom);
                    if (len == 2)
                        tok_bytes.push_back({3'b110, b[4:0]});
                    else if (len == 3)
                        tok_bytes.push_back({4'b1110, b[3:0]});
                    else
                        tok_bytes.push_back({5'b11110, b[2:0]});
                    repeat ($urandom_range(0, len - 2)) begin
                        b = 8'($urandom);
                        tok_bytes.push_back({2'b10, b[5:0]});
                    end
                end
                default: begin
                    b = 8'($urandom);
                    tok_bytes.push_back(b);
                end
            endcase
        end
    endtask

    task automatic test_escapes();
        tok_bytes = {PCT_CHAR, "7", "F"};
        send_token(1'b1);
        // high escape mid token, trailing byte dropped
        tok_bytes = {PCT_CHAR, "e", "9", "x"};
        send_token(1'b1);
        tok_bytes = {PCT_CHAR, "4", "g"};
        send_token(1'b1);
    endtask

    task automatic test_utf8();
        // two-, three-, four-byte forms, then a sequence cut by the token end
        tok_bytes = {8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80,
                     8'hE2, 8'h82};
        send_token(1'b1);
    endtask

    task automatic test_edges();
        // stray continuation, invalid lead, four-byte form above the scalar range
        tok_bytes = {8'h80, 8'hF8, 8'hF4, 8'h90, 8'h80, 8'h80, 8'h00, 8'hFF};
        send_token(1'b1);
    endtask

    task automatic test_random(input int src_pct, input int sink_pct, input int n_bytes);
        int goal;
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        goal = live_bytes + n_bytes;
        while (live_bytes < goal) begin
            build_token();
            send_token(1'b1);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_escapes();
        test_utf8();
        test_edges();
        test_random(0, 0, 62);
        test_random(46, 0, 62);
        test_random(0, 46, 62);
        test_random(11, 11, 62);

        s_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("percent_utf8_decoder verification clean");
        else
            $display("percent_utf8_decoder verification failed");
        $finish;
    end

endmodule
